@@ hw/rtl/assert_macros.svh @@
// Shared assertion macros for the date adder checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GDAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GDAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/gdas_pkg.sv @@
package gdas_pkg;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [15:0] offset_days;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic        input_is_leap;
    logic [8:0]  input_day_of_year;
    logic        range_error;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MODSUB,
    OP_CLAMPD,
    OP_DOYACC,
    OP_INITREM,
    OP_YADD,
    OP_YSUB,
    OP_MINIT,
    OP_MSTEP,
    OP_FIN,
    OP_FINERR
  } op_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_SUB,
    C_MI_LT,
    C_REM_GE_YLEN,
    C_REM_NEG_NZ,
    C_REM_NEG,
    C_RY_BAD,
    C_REM_GE_MLEN,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t        op;
    cond_t      cnd;
    logic       jmp;
    logic       last;
    logic [2:0] arg;
    logic [4:0] tgt;
  } uword_t;

  typedef struct packed {
    logic sub;
    logic mi_lt;
    logic rem_ge_ylen;
    logic rem_neg_nz;
    logic rem_neg;
    logic ry_bad;
    logic rem_ge_mlen;
    logic out_free;
  } flags_t;

  typedef struct packed {
    logic       exec;
    op_t        op;
    logic [2:0] arg;
  } ctl_t;

  localparam int PC_W = 5;

  localparam logic [PC_W-1:0] PC_SUB   = 5'd12;
  localparam logic [PC_W-1:0] PC_CHECK = 5'd14;
  localparam logic [PC_W-1:0] PC_ERR   = 5'd18;

  localparam logic [13:0] MOD_BASE = 14'd400;
  localparam logic [14:0] YEAR_MAX = 15'd9999;

  function automatic uword_t uw_mk(op_t op, cond_t cnd, logic jmp, logic last,
                                   logic [2:0] arg, logic [PC_W-1:0] tgt);
    uword_t w;
    w.op   = op;
    w.cnd  = cnd;
    w.jmp  = jmp;
    w.last = last;
    w.arg  = arg;
    w.tgt  = tgt;
    return w;
  endfunction

  // Microprogram. A word runs its op when its condition holds; a jump word then
  // branches, otherwise the step counter advances. Loop words jump to themselves.
  function automatic uword_t uw_rom(logic [PC_W-1:0] pc);
    uword_t w;
    w = uw_mk(OP_NOP, C_ALWAYS, 1'b0, 1'b0, 3'd0, 5'd0);
    case (pc)
      5'd0:  w = uw_mk(OP_MODSUB,  C_ALWAYS,      1'b0, 1'b0, 3'd5, 5'd0);
      5'd1:  w = uw_mk(OP_MODSUB,  C_ALWAYS,      1'b0, 1'b0, 3'd4, 5'd0);
      5'd2:  w = uw_mk(OP_MODSUB,  C_ALWAYS,      1'b0, 1'b0, 3'd3, 5'd0);
      5'd3:  w = uw_mk(OP_MODSUB,  C_ALWAYS,      1'b0, 1'b0, 3'd2, 5'd0);
      5'd4:  w = uw_mk(OP_MODSUB,  C_ALWAYS,      1'b0, 1'b0, 3'd1, 5'd0);
      5'd5:  w = uw_mk(OP_MODSUB,  C_ALWAYS,      1'b0, 1'b0, 3'd0, 5'd0);
      5'd6:  w = uw_mk(OP_CLAMPD,  C_ALWAYS,      1'b0, 1'b0, 3'd0, 5'd0);
      5'd7:  w = uw_mk(OP_DOYACC,  C_MI_LT,       1'b1, 1'b0, 3'd0, 5'd7);
      5'd8:  w = uw_mk(OP_INITREM, C_ALWAYS,      1'b0, 1'b0, 3'd0, 5'd0);
      5'd9:  w = uw_mk(OP_NOP,     C_SUB,         1'b1, 1'b0, 3'd0, PC_SUB);
      5'd10: w = uw_mk(OP_YADD,    C_REM_GE_YLEN, 1'b1, 1'b0, 3'd0, 5'd10);
      5'd11: w = uw_mk(OP_NOP,     C_ALWAYS,      1'b1, 1'b0, 3'd0, PC_CHECK);
      5'd12: w = uw_mk(OP_YSUB,    C_REM_NEG_NZ,  1'b1, 1'b0, 3'd0, 5'd12);
      5'd13: w = uw_mk(OP_NOP,     C_REM_NEG,     1'b1, 1'b0, 3'd0, PC_ERR);
      5'd14: w = uw_mk(OP_NOP,     C_RY_BAD,      1'b1, 1'b0, 3'd0, PC_ERR);
      5'd15: w = uw_mk(OP_MINIT,   C_ALWAYS,      1'b0, 1'b0, 3'd0, 5'd0);
      5'd16: w = uw_mk(OP_MSTEP,   C_REM_GE_MLEN, 1'b1, 1'b0, 3'd0, 5'd16);
      5'd17: w = uw_mk(OP_FIN,     C_OUT_FREE,    1'b0, 1'b1, 3'd0, 5'd0);
      5'd18: w = uw_mk(OP_FINERR,  C_OUT_FREE,    1'b0, 1'b1, 3'd0, 5'd0);
      default: w = uw_mk(OP_NOP, C_ALWAYS, 1'b0, 1'b1, 3'd0, 5'd0);
    endcase
    return w;
  endfunction

  // c400 is the year modulo 400, lo2 the year's two low bits.
  function automatic logic leap_f(logic [8:0] c400, logic [1:0] lo2);
    logic century;
    century = (c400 == 9'd0) || (c400 == 9'd100) || (c400 == 9'd200) ||
              (c400 == 9'd300);
    return century ? (c400 == 9'd0) : (lo2 == 2'd0);
  endfunction

  function automatic logic [4:0] month_len(logic leap, logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] year_len(logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

@@ hw/rtl/gdas_seq.sv @@
module gdas_seq
  import gdas_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  flags_t flags,
  output ctl_t   ctl,
  output logic   busy
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            busy_r, busy_nxt;
  uword_t          uw;
  logic            cond_ok;

  assign uw = uw_rom(pc_r);

  always_comb begin
    case (uw.cnd)
      C_ALWAYS:      cond_ok = 1'b1;
      C_SUB:         cond_ok = flags.sub;
      C_MI_LT:       cond_ok = flags.mi_lt;
      C_REM_GE_YLEN: cond_ok = flags.rem_ge_ylen;
      C_REM_NEG_NZ:  cond_ok = flags.rem_neg_nz;
      C_REM_NEG:     cond_ok = flags.rem_neg;
      C_RY_BAD:      cond_ok = flags.ry_bad;
      C_REM_GE_MLEN: cond_ok = flags.rem_ge_mlen;
      C_OUT_FREE:    cond_ok = flags.out_free;
      default:       cond_ok = 1'b0;
    endcase
  end

  assign ctl.exec = busy_r && cond_ok;
  assign ctl.op   = uw.op;
  assign ctl.arg  = uw.arg;
  assign busy     = busy_r;

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = '0;
      end
    end else if (uw.last) begin
      // hold on the final word until the output register can take the word
      if (cond_ok) begin
        busy_nxt = 1'b0;
      end
    end else if (cond_ok && uw.jmp) begin
      pc_nxt = uw.tgt;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

@@ hw/rtl/gregorian_date_add_subtract_core.sv @@
// Gregorian date plus or minus a day count.
//
// Input channel (in_valid / in_stall / in_data) carries one request word: a
// date, an offset in days and an add/subtract select. Output channel
// (out_valid / out_stall / out_data) returns one result word per request:
// the resulting date, the input year's leap flag, the input day of year and
// a range error flag. On range error the date fields echo the raw input.
//
// A request is taken whenever the block is idle; in_stall is high while one
// is in work. The word is processed by a small microprogram: 6 steps reduce
// the year modulo 400, up to 12 steps sum the day of year, then the year
// loop runs one calendar year per cycle and the month loop one month per
// cycle. The next request can be taken as soon as the result is in the
// output register. The year loop sets the rate.
//
// A finished result sits in the output register while out_stall is high; a
// new request may already be accepted then, and its final step waits for the
// register to drain. Synchronous reset drops any word in work or waiting.
module gregorian_date_add_subtract_core
  import gdas_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  in_word_t         in_r, in_nxt;
  logic [14:0]      ry_r, ry_nxt;
  logic [13:0]      c400_r, c400_nxt;
  logic signed [17:0] rem_r, rem_nxt;
  logic [3:0]       mc_r, mc_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [8:0]       doy_r, doy_nxt;
  logic             leap_in_r, leap_in_nxt;
  out_word_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  ctl_t             ctl;
  flags_t           flags;
  logic             busy;
  logic             accept;

  logic             leap_cur;
  logic             leap_dec;
  logic [14:0]      ry_dec;
  logic [8:0]       c400_dec;
  logic [8:0]       c400_inc;
  logic [4:0]       mlen_clamp;
  logic [4:0]       mlen_cnt;
  logic signed [17:0] ylen_cur;
  logic signed [17:0] ylen_dec;
  logic signed [17:0] mlen_cnt_s;
  logic [13:0]      modsub_val;
  logic [4:0]       day_clamped;
  logic [3:0]       mon_clamped;
  logic signed [17:0] rem_base;
  logic signed [17:0] off_s;

  assign accept   = in_valid && !busy;
  assign in_stall = busy;

  assign leap_cur   = leap_f(c400_r[8:0], ry_r[1:0]);
  assign ry_dec     = ry_r - 15'd1;
  assign c400_dec   = (c400_r[8:0] == 9'd0) ? 9'd399 : c400_r[8:0] - 9'd1;
  assign c400_inc   = (c400_r[8:0] == 9'd399) ? 9'd0 : c400_r[8:0] + 9'd1;
  assign leap_dec   = leap_f(c400_dec, ry_dec[1:0]);
  assign mlen_clamp = month_len(leap_cur, mc_r);
  assign mlen_cnt   = month_len(leap_cur, cnt_r);
  assign ylen_cur   = $signed({9'd0, year_len(leap_cur)});
  assign ylen_dec   = $signed({9'd0, year_len(leap_dec)});
  assign mlen_cnt_s = $signed({13'd0, mlen_cnt});
  assign modsub_val = MOD_BASE << ctl.arg;
  assign rem_base   = $signed({9'd0, doy_r - 9'd1});
  assign off_s      = $signed({2'd0, in_r.offset_days});

  always_comb begin
    if (in_data.start_month == 4'd0) begin
      mon_clamped = 4'd1;
    end else if (in_data.start_month > 4'd12) begin
      mon_clamped = 4'd12;
    end else begin
      mon_clamped = in_data.start_month;
    end
  end

  always_comb begin
    if (in_r.start_day == 5'd0) begin
      day_clamped = 5'd1;
    end else if (in_r.start_day > mlen_clamp) begin
      day_clamped = mlen_clamp;
    end else begin
      day_clamped = in_r.start_day;
    end
  end

  always_comb begin
    flags.sub         = in_r.req_type;
    flags.mi_lt       = (cnt_r != mc_r);
    flags.rem_ge_ylen = (rem_r >= ylen_cur);
    flags.rem_neg_nz  = rem_r[17] && (ry_r != 15'd0);
    flags.rem_neg     = rem_r[17];
    flags.ry_bad      = (ry_r == 15'd0) || (ry_r > YEAR_MAX);
    flags.rem_ge_mlen = (cnt_r != 4'd12) && (rem_r >= mlen_cnt_s);
    flags.out_free    = !out_valid_r || !out_stall;
  end

  gdas_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .flags (flags),
    .ctl   (ctl),
    .busy  (busy)
  );

  always_comb begin
    in_nxt        = in_r;
    ry_nxt        = ry_r;
    c400_nxt      = c400_r;
    rem_nxt       = rem_r;
    mc_nxt        = mc_r;
    cnt_nxt       = cnt_r;
    doy_nxt       = doy_r;
    leap_in_nxt   = leap_in_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (accept) begin
      in_nxt   = in_data;
      ry_nxt   = {1'b0, in_data.start_year};
      c400_nxt = in_data.start_year;
      mc_nxt   = mon_clamped;
    end

    if (ctl.exec) begin
      case (ctl.op)
        OP_NOP: begin
        end
        OP_MODSUB: begin
          if (c400_r >= modsub_val) begin
            c400_nxt = c400_r - modsub_val;
          end
        end
        OP_CLAMPD: begin
          doy_nxt = {4'd0, day_clamped};
          cnt_nxt = 4'd1;
        end
        OP_DOYACC: begin
          doy_nxt = doy_r + {4'd0, mlen_cnt};
          cnt_nxt = cnt_r + 4'd1;
        end
        OP_INITREM: begin
          rem_nxt     = in_r.req_type ? (rem_base - off_s) : (rem_base + off_s);
          leap_in_nxt = leap_cur;
        end
        OP_YADD: begin
          rem_nxt  = rem_r - ylen_cur;
          ry_nxt   = ry_r + 15'd1;
          c400_nxt = {5'd0, c400_inc};
        end
        OP_YSUB: begin
          // step back one year and add the length of that earlier year
          rem_nxt  = rem_r + ylen_dec;
          ry_nxt   = ry_dec;
          c400_nxt = {5'd0, c400_dec};
        end
        OP_MINIT: begin
          cnt_nxt = 4'd1;
        end
        OP_MSTEP: begin
          rem_nxt = rem_r - mlen_cnt_s;
          cnt_nxt = cnt_r + 4'd1;
        end
        OP_FIN: begin
          out_nxt.result_day        = rem_r[4:0] + 5'd1;
          out_nxt.result_month      = cnt_r;
          out_nxt.result_year       = ry_r[13:0];
          out_nxt.input_is_leap     = leap_in_r;
          out_nxt.input_day_of_year = doy_r;
          out_nxt.range_error       = 1'b0;
          out_valid_nxt             = 1'b1;
        end
        OP_FINERR: begin
          out_nxt.result_day        = in_r.start_day;
          out_nxt.result_month      = in_r.start_month;
          out_nxt.result_year       = in_r.start_year;
          out_nxt.input_is_leap     = leap_in_r;
          out_nxt.input_day_of_year = doy_r;
          out_nxt.range_error       = 1'b1;
          out_valid_nxt             = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    in_r      <= in_nxt;
    ry_r      <= ry_nxt;
    c400_r    <= c400_nxt;
    rem_r     <= rem_nxt;
    mc_r      <= mc_nxt;
    cnt_r     <= cnt_nxt;
    doy_r     <= doy_nxt;
    leap_in_r <= leap_in_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hw/rtl/gdas_checker.sv @@
`include "assert_macros.svh"

module gdas_checker
  import gdas_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  logic date_ok;
  logic doy_ok;

  assign date_ok = (out_data.result_year != 14'd0) && (out_data.result_year <= 14'd9999) &&
                   (out_data.result_month != 4'd0) && (out_data.result_month <= 4'd12) &&
                   (out_data.result_day != 5'd0);
  assign doy_ok  = (out_data.input_day_of_year != 9'd0) &&
                   (out_data.input_day_of_year <= 9'd366);

  `GDAS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result word changed while stalled")
  `GDAS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall && !in_data.req_type, in_stall, "request accepted but block not busy")
  `GDAS_ASSERT_NOW(a_date_range, out_valid && !out_data.range_error, date_ok, "result date out of range without error flag")
  `GDAS_ASSERT_NOW(a_doy_range, out_valid, doy_ok, "input day of year out of range")

endmodule

bind gregorian_date_add_subtract_core gdas_checker u_gdas_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import gdas_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned RANDOM_WORDS = 400;

  typedef struct {
    in_word_t word;
    bit       drain;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  pending_t    pending_words[$];
  out_word_t   dates_due[$];
  bit          word_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic        stall_level = 1'b0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned range_errors_seen = 0;
  int unsigned leap_inputs_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  gregorian_date_add_subtract_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit leap_year(longint unsigned y);
    if (y % 100 == 0) return (y % 400 == 0);
    return (y % 4 == 0);
  endfunction

  function automatic int unsigned days_in_month(longint unsigned y, int unsigned m);
    case (m)
      2:          return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  // days in years 0 .. y-1, year 0 being a leap year
  function automatic longint unsigned days_ahead_of(longint unsigned y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic out_word_t shift_date(in_word_t w);
    longint unsigned y, serial, target, ry, rem;
    int unsigned     m, d, doy, rm, rd, i;
    bit              err;
    out_word_t       r;
    y   = w.start_year;
    m   = w.start_month;
    d   = w.start_day;
    err = 1'b0;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (d < 1) d = 1;
    if (d > days_in_month(y, m)) d = days_in_month(y, m);
    doy = d;
    for (i = 1; i < m; i++) doy += days_in_month(y, i);
    serial = days_ahead_of(y) + doy - 1;
    target = 0;
    if (!w.req_type) begin
      target = serial + w.offset_days;
    end else if (w.offset_days > serial) begin
      err = 1'b1;
    end else begin
      target = serial - w.offset_days;
    end
    ry = 0;
    rm = 1;
    rd = 1;
    if (!err) begin
      ry = (target * 400) / 146097;
      while (ry > 0 && days_ahead_of(ry) > target) ry--;
      while (days_ahead_of(ry + 1) <= target) ry++;
      if (ry < 1 || ry > 9999) begin
        err = 1'b1;
      end else begin
        rem = target - days_ahead_of(ry);
        while (rm < 12 && rem >= days_in_month(ry, rm)) begin
          rem -= days_in_month(ry, rm);
          rm++;
        end
        rd = 32'(rem) + 1;
      end
    end
    if (err) begin
      r.result_day   = w.start_day;
      r.result_month = w.start_month;
      r.result_year  = w.start_year;
    end else begin
      r.result_day   = rd[4:0];
      r.result_month = rm[3:0];
      r.result_year  = ry[13:0];
    end
    r.input_is_leap     = leap_year(y);
    r.input_day_of_year = doy[8:0];
    r.range_error       = err;
    return r;
  endfunction

  task automatic queue_word(input logic sub, input logic [4:0] d, input logic [3:0] m,
                            input logic [13:0] y, input logic [15:0] off, input bit drain);
    pending_t p;
    p.word.req_type    = sub;
    p.word.start_day   = d;
    p.word.start_month = m;
    p.word.start_year  = y;
    p.word.offset_days = off;
    p.drain            = drain;
    pending_words.push_back(p);
  endtask

  task automatic queue_random_word(input bit drain);
    int unsigned y, m, d, off, pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      // raw fields, out-of-range values included
      queue_word(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                 4'($urandom_range(0, 15)), 14'($urandom_range(0, 16383)),
                 16'($urandom_range(0, 65535)), drain);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50) y = $urandom_range(1, 9999);
      else if (pick < 65) y = $urandom_range(1, 250);
      else if (pick < 80) y = $urandom_range(9750, 9999);
      else y = 100 * $urandom_range(1, 99) + $urandom_range(0, 1);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, days_in_month(y, m));
      pick = $urandom_range(0, 99);
      if (pick < 40) off = $urandom_range(0, 65535);
      else if (pick < 85) off = $urandom_range(0, 1000);
      else off = $urandom_range(65000, 65535);
      queue_word(1'($urandom_range(0, 1)), d[4:0], m[3:0], y[13:0], off[15:0], drain);
    end
  endtask

  // keep a quiet window with no sender gaps in the middle of the run
  function automatic int unsigned idle_cycles(int unsigned sent);
    int unsigned pick;
    if (sent >= 230 && sent < 290) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // sender: hold a word until taken, then idle for a while
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !word_taken)) begin
      if (word_taken) begin
        word_taken = 1'b0;
        gap_left   = idle_cycles(words_sent);
      end
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0 &&
                   !(pending_words[0].drain && dates_due.size() != 0)) begin
        in_data  <= pending_words[0].word;
        in_valid <= 1'b1;
        pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall and free runs of random length, picked at random
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left == 0) begin
        case ($urandom_range(0, 3))
          0: begin stall_level = 1'b0; stall_left = $urandom_range(1, 8); end
          1: begin stall_level = 1'b1; stall_left = $urandom_range(1, 3); end
          2: begin
            stall_level = $urandom_range(0, 9) == 0;
            stall_left  = stall_level ? $urandom_range(20, 80) : $urandom_range(20, 120);
          end
          default: begin stall_level = 1'b0; stall_left = $urandom_range(1, 4); end
        endcase
      end
      stall_left--;
      out_stall <= stall_level;
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (dates_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result word with nothing outstanding: %p", $realtime, out_data);
      end else begin
        want = dates_due.pop_front();
        results_checked++;
        if (out_data.range_error) range_errors_seen++;
        if (out_data.result_day !== want.result_day ||
            out_data.result_month !== want.result_month ||
            out_data.result_year !== want.result_year ||
            out_data.input_is_leap !== want.input_is_leap ||
            out_data.input_day_of_year !== want.input_day_of_year ||
            out_data.range_error !== want.range_error) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] result %0d: want %0d/%0d/%0d leap %0b doy %0d err %0b",
                     $realtime, results_checked,
                     want.result_day, want.result_month, want.result_year,
                     want.input_is_leap, want.input_day_of_year, want.range_error);
            $display("    got %0d/%0d/%0d leap %0b doy %0d err %0b",
                     out_data.result_day, out_data.result_month, out_data.result_year,
                     out_data.input_is_leap, out_data.input_day_of_year,
                     out_data.range_error);
          end
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      dates_due.push_back(shift_date(in_data));
      if (leap_year(in_data.start_year)) leap_inputs_seen++;
      words_sent++;
      word_taken = 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    // corner dates, clamping of raw fields and both range-error directions
    queue_word(1'b0, 5'd1,  4'd1,  14'd1,     16'd0,     1'b0);
    queue_word(1'b1, 5'd31, 4'd12, 14'd9999,  16'd0,     1'b0);
    queue_word(1'b0, 5'd31, 4'd12, 14'd9999,  16'd1,     1'b0);
    queue_word(1'b1, 5'd1,  4'd1,  14'd1,     16'd1,     1'b0);
    queue_word(1'b0, 5'd29, 4'd2,  14'd2000,  16'd365,   1'b0);
    queue_word(1'b0, 5'd29, 4'd2,  14'd1900,  16'd0,     1'b0);
    queue_word(1'b1, 5'd0,  4'd0,  14'd2024,  16'd1,     1'b0);
    queue_word(1'b0, 5'd31, 4'd15, 14'd2023,  16'd1,     1'b0);
    queue_word(1'b0, 5'd31, 4'd13, 14'd2023,  16'd0,     1'b0);
    queue_word(1'b0, 5'd31, 4'd4,  14'd2023,  16'd0,     1'b0);
    queue_word(1'b0, 5'd1,  4'd1,  14'd0,     16'd0,     1'b0);
    queue_word(1'b0, 5'd31, 4'd12, 14'd0,     16'd1,     1'b0);
    queue_word(1'b1, 5'd1,  4'd1,  14'd0,     16'd1,     1'b0);
    queue_word(1'b0, 5'd1,  4'd1,  14'd16383, 16'd65535, 1'b0);
    queue_word(1'b1, 5'd1,  4'd3,  14'd10000, 16'd65535, 1'b0);
    queue_word(1'b0, 5'd1,  4'd1,  14'd1,     16'd65535, 1'b0);
    queue_word(1'b1, 5'd31, 4'd12, 14'd9999,  16'd65535, 1'b0);
    queue_word(1'b1, 5'd31, 4'd15, 14'd16383, 16'd65535, 1'b0);
    queue_word(1'b0, 5'd28, 4'd2,  14'd2100,  16'd1,     1'b0);
    queue_word(1'b0, 5'd28, 4'd2,  14'd2400,  16'd1,     1'b0);
    queue_word(1'b1, 5'd1,  4'd3,  14'd2000,  16'd1,     1'b0);
    queue_word(1'b0, 5'd31, 4'd12, 14'd2400,  16'd0,     1'b0);
    queue_word(1'b1, 5'd15, 4'd6,  14'd179,   16'd65535, 1'b0);
    queue_word(1'b0, 5'd30, 4'd11, 14'd9819,  16'd65535, 1'b0);
    // drain the block before some random words
    for (int i = 0; i < RANDOM_WORDS; i++)
      queue_random_word(i % 150 == 0);

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (dates_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("tb_top: %0d request words sent, %0d result words checked, %0d mismatches",
             words_sent, results_checked, mismatches);
    $display("tb_top: %0d results flagged out of range, %0d requests in leap years",
             range_errors_seen, leap_inputs_seen);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
